// ===== rtl/core/vft_pkg.sv =====
`timescale 1ns / 1ps
package vft_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam int ROOT_STAGES = 8;
  localparam int DIV_STAGES  = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_Z  = 3'd2,
    REG_OFS_X  = 3'd3,
    REG_OFS_Y  = 3'd4,
    REG_OFS_Z  = 3'd5,
    REG_QUAT   = 3'd6,
    REG_UNUSED = 3'd7
  } reg_idx_t;

  localparam logic OP_POSITION = 1'b0;
  localparam logic OP_NORMAL   = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } vft_in_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } vft_out_t;

  typedef struct packed {
    logic [62:0] row_x;
    logic [62:0] row_y;
    logic [62:0] row_z;
    logic signed [39:0] ofs_x;
    logic signed [39:0] ofs_y;
    logic signed [39:0] ofs_z;
    logic [63:0] quat;
  } vft_cfg_t;

  typedef struct packed {
    logic               op;
    logic               zero;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } vft_aux_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/vertex_frame_transform_top.sv =====
`timescale 1ns / 1ps
// Channel  Handshake               Payload
// in_      in_valid / in_ready     vft_in_t in_data
// out_     out_valid / out_ready   vft_out_t out_data
// cfg_     cfg_valid / cfg_ready   cfg_index, cfg_data
// One beat enters per cycle, unless a stall on out_ready holds the pipeline.
// Each result passes through the square root and divide stages of the normal path.
// Reset clears the pipeline valid bits and loads the configuration defaults.
// A stall on out_ready freezes every stage in place, so nothing is lost.
module vertex_frame_transform_top
  import vft_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vft_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vft_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  vft_cfg_t cfg;

  vft_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  vft_pipe #(.COORD_BITS(COORD_BITS)) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/vft_cfg.sv =====
`timescale 1ns / 1ps
module vft_cfg
  import vft_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output vft_cfg_t              cfg_o
);

  vft_cfg_t cfg_r;
  reg_idx_t idx;

  assign cfg_ready = 1'b1;
  assign idx = reg_idx_t'(cfg_index);
  assign cfg_o = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{row_x: '0, row_y: '0, row_z: '0, ofs_x: '0, ofs_y: '0, ofs_z: '0,
                 quat: 64'h40000000};
    end else if (cfg_valid) begin
      unique case (idx)
        REG_ROW_X: cfg_r.row_x <= cfg_data[62:0];
        REG_ROW_Y: cfg_r.row_y <= cfg_data[62:0];
        REG_ROW_Z: cfg_r.row_z <= cfg_data[62:0];
        REG_OFS_X: cfg_r.ofs_x <= cfg_data[39:0];
        REG_OFS_Y: cfg_r.ofs_y <= cfg_data[39:0];
        REG_OFS_Z: cfg_r.ofs_z <= cfg_data[39:0];
        REG_QUAT:  cfg_r.quat  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/vft_pipe.sv =====
`timescale 1ns / 1ps
module vft_pipe
  import vft_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  vft_cfg_t cfg_i,
  input  logic     in_valid,
  output logic     in_ready,
  input  vft_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output vft_out_t out_data
);

  localparam int POS_BITS = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int NS = 8 + ROOT_STAGES + DIV_STAGES;
  localparam int LAST = NS - 1;

  logic [NS-1:0] v_r;
  logic adv;
  assign adv = out_ready || !v_r[LAST];
  assign in_ready = adv;
  assign out_valid = v_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], in_valid};
  end

  // Stage 1: linear products.
  logic op1_r;
  logic signed [52:0] p1_r [9];
  // Stage 2: row sums, rounding and, for positions only, offset.
  logic op2_r;
  logic signed [56:0] a2_r [3];
  // Stage 3: split into high and low parts; rotation matrix.
  logic op3_r;
  logic signed [21:0] vh3_r [3];
  logic signed [20:0] vl3_r [3];
  logic signed [36:0] m3_r [9];
  // Stage 4: rotation products.
  logic op4_r;
  logic signed [73:0] ph4_r [9];
  logic signed [57:0] pl4_r [9];
  // Stage 5: rotation sums.
  logic op5_r;
  logic signed [63:0] b5_r [3];

  logic signed [20:0] kc [9];
  logic signed [15:0] qx, qy, qz, qw;
  logic signed [36:0] mm [9];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      logic [62:0] row;
      row = (r == 0) ? cfg_i.row_x : ((r == 1) ? cfg_i.row_y : cfg_i.row_z);
      kc[r*3+0] = row[62:42];
      kc[r*3+1] = row[41:21];
      kc[r*3+2] = row[20:0];
    end
    qx = cfg_i.quat[63:48];
    qy = cfg_i.quat[47:32];
    qz = cfg_i.quat[31:16];
    qw = cfg_i.quat[15:0];
    mm[0] = 37'sd268435456 - 37'sd2 * (37'(qy*qy) + 37'(qz*qz));
    mm[1] = 37'sd2 * (37'(qx*qy) - 37'(qw*qz));
    mm[2] = 37'sd2 * (37'(qx*qz) + 37'(qw*qy));
    mm[3] = 37'sd2 * (37'(qx*qy) + 37'(qw*qz));
    mm[4] = 37'sd268435456 - 37'sd2 * (37'(qx*qx) + 37'(qz*qz));
    mm[5] = 37'sd2 * (37'(qy*qz) - 37'(qw*qx));
    mm[6] = 37'sd2 * (37'(qx*qz) - 37'(qw*qy));
    mm[7] = 37'sd2 * (37'(qy*qz) + 37'(qw*qx));
    mm[8] = 37'sd268435456 - 37'sd2 * (37'(qx*qx) + 37'(qy*qy));
  end

  logic signed [31:0] vin [3];
  assign vin[0] = in_data.in_x;
  assign vin[1] = in_data.in_y;
  assign vin[2] = in_data.in_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= in_data.opcode;
      for (int i = 0; i < 9; i++) p1_r[i] <= 53'(kc[i] * vin[i%3]);
      op2_r <= op1_r;
      for (int r = 0; r < 3; r++) begin
        logic signed [56:0] s;
        logic signed [39:0] ofs;
        ofs = (r == 0) ? cfg_i.ofs_x : ((r == 1) ? cfg_i.ofs_y : cfg_i.ofs_z);
        s = 57'(p1_r[r*3]) + 57'(p1_r[r*3+1]) + 57'(p1_r[r*3+2]) + 57'sd131072;
        s = s >>> 18;
        a2_r[r] <= (op1_r == OP_POSITION) ? s + 57'(ofs) : s;
      end
      op3_r <= op2_r;
      for (int c = 0; c < 3; c++) begin
        vh3_r[c] <= 22'(a2_r[c] >>> 20);
        vl3_r[c] <= {1'b0, a2_r[c][19:0]};
      end
      for (int i = 0; i < 9; i++) m3_r[i] <= mm[i];
      op4_r <= op3_r;
      for (int i = 0; i < 9; i++) begin
        ph4_r[i] <= 74'(m3_r[i] * vh3_r[i%3]);
        pl4_r[i] <= 58'(m3_r[i] * vl3_r[i%3]);
      end
      op5_r <= op4_r;
      for (int r = 0; r < 3; r++) begin
        logic signed [75:0] sh;
        logic signed [60:0] sl;
        sh = 76'(ph4_r[r*3]) + 76'(ph4_r[r*3+1]) + 76'(ph4_r[r*3+2]);
        sl = 61'(pl4_r[r*3]) + 61'(pl4_r[r*3+1]) + 61'(pl4_r[r*3+2]) + 61'sd134217728;
        sh = (sh + 76'(sl >>> 20)) >>> 8;
        b5_r[r] <= 64'(sh);
      end
    end
  end

  // Stage 6: position saturation, normal magnitudes and leading scale.
  logic op6_r, zero6_r;
  logic signed [31:0] pos6_r [3];
  logic signed [63:0] b6_r [3];
  logic [6:0] sh6_r;
  logic sdir6_r;
  logic [63:0] amax;
  logic [6:0] msb;
  always_comb begin
    amax = '0;
    for (int i = 0; i < 3; i++) begin
      logic [63:0] a;
      a = b5_r[i][63] ? 64'(-b5_r[i]) : 64'(b5_r[i]);
      amax = amax | a;
    end
    msb = '0;
    for (int k = 0; k < 64; k++) if (amax[k]) msb = 7'(k);
  end

  function automatic logic signed [31:0] satp(input logic signed [63:0] v);
    logic signed [63:0] hi, lo;
    logic signed [31:0] r;
    hi = (64'sd1 <<< (POS_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) r = hi[31:0];
    else if (v < lo) r = lo[31:0];
    else r = v[31:0];
    return r;
  endfunction

  // With the OR of magnitudes, the max's top bit equals the OR's top bit.
  always_ff @(posedge clk) begin
    if (adv) begin
      op6_r <= op5_r;
      zero6_r <= (b5_r[0] == 0) && (b5_r[1] == 0) && (b5_r[2] == 0);
      for (int i = 0; i < 3; i++) begin
        pos6_r[i] <= satp(b5_r[i]);
        b6_r[i] <= b5_r[i];
      end
      sdir6_r <= (msb >= 7'd31);
      sh6_r <= (msb >= 7'd31) ? 7'(msb - 7'd30) : 7'(7'd30 - msb);
    end
  end

  // Stage 7: scaled components.
  logic op7_r, zero7_r;
  logic signed [31:0] pos7_r [3];
  logic signed [31:0] w7_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      op7_r <= op6_r;
      zero7_r <= zero6_r;
      pos7_r <= pos6_r;
      for (int i = 0; i < 3; i++)
        w7_r[i] <= sdir6_r ? 32'(b6_r[i] >>> sh6_r) : 32'(b6_r[i] <<< sh6_r);
    end
  end

  // Stage 8: squares.
  logic op8_r, zero8_r;
  logic signed [31:0] pos8_r [3];
  logic signed [31:0] w8_r [3];
  logic [63:0] sq8_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      op8_r <= op7_r;
      zero8_r <= zero7_r;
      pos8_r <= pos7_r;
      w8_r <= w7_r;
      for (int i = 0; i < 3; i++) begin
        logic [31:0] a;
        a = w7_r[i][31] ? 32'(-w7_r[i]) : 32'(w7_r[i]);
        sq8_r[i] <= 64'(a) * 64'(a);
      end
    end
  end

  // Stage 9: sum of squares, then the square root and division unit.
  logic [63:0] ss;
  assign ss = sq8_r[0] + sq8_r[1] + sq8_r[2];

  vft_aux_t aux_in, aux_out;
  assign aux_in.op = op8_r;
  assign aux_in.zero = zero8_r;
  assign aux_in.pos_x = pos8_r[0];
  assign aux_in.pos_y = pos8_r[1];
  assign aux_in.pos_z = pos8_r[2];

  logic signed [31:0] nrm [3];
  vft_norm u_norm (
    .clk   (clk),
    .adv   (adv),
    .sumsq (ss),
    .w_x   (w8_r[0]),
    .w_y   (w8_r[1]),
    .w_z   (w8_r[2]),
    .aux_i (aux_in),
    .n_x   (nrm[0]),
    .n_y   (nrm[1]),
    .n_z   (nrm[2]),
    .aux_o (aux_out)
  );

  always_comb begin
    out_data.kind = aux_out.op;
    if (aux_out.op == OP_POSITION) begin
      out_data.out_x = aux_out.pos_x;
      out_data.out_y = aux_out.pos_y;
      out_data.out_z = aux_out.pos_z;
    end else if (aux_out.zero) begin
      out_data.out_x = '0;
      out_data.out_y = 32'sh40000000;
      out_data.out_z = '0;
    end else begin
      out_data.out_x = nrm[0];
      out_data.out_y = nrm[1];
      out_data.out_z = nrm[2];
    end
  end

endmodule

// ===== rtl/core/vft_norm.sv =====
`timescale 1ns / 1ps
module vft_norm
  import vft_pkg::*;
(
  input  logic               clk,
  input  logic               adv,
  input  logic [63:0]        sumsq,
  input  logic signed [31:0] w_x,
  input  logic signed [31:0] w_y,
  input  logic signed [31:0] w_z,
  input  vft_aux_t           aux_i,
  output logic signed [31:0] n_x,
  output logic signed [31:0] n_y,
  output logic signed [31:0] n_z,
  output vft_aux_t           aux_o
);

  // Root: 32 result bits, four per stage over eight stages.
  // Divide: three lanes of 63 numerator bits, seven per stage over nine stages.
  localparam int RS = ROOT_STAGES;
  localparam int DS = DIV_STAGES;
  localparam int RB = 32 / RS;
  localparam int DB = 63 / DS;

  logic [63:0]  rn_r  [RS+1];
  logic [31:0]  rq_r  [RS+1];
  logic signed [31:0] rw_r [RS+1][3];
  vft_aux_t     ra_r  [RS+1];

  always_comb begin
    rn_r[0] = sumsq;
    rq_r[0] = '0;
    rw_r[0][0] = w_x;
    rw_r[0][1] = w_y;
    rw_r[0][2] = w_z;
    ra_r[0] = aux_i;
  end

  for (genvar s = 0; s < RS; s++) begin : g_root
    logic [63:0] n_n;
    logic [31:0] q_n;
    always_comb begin
      logic [67:0] rem, trial;
      n_n = rn_r[s];
      q_n = rq_r[s];
      for (int k = 0; k < RB; k++) begin
        int b;
        b = 31 - s*RB - k;
        trial = {36'd0, q_n} << (b + 1);
        trial = trial | (68'd1 << (2*b));
        rem = {4'd0, n_n};
        if (rem >= trial) begin
          n_n = 64'(rem - trial);
          q_n = q_n | (32'd1 << b);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rn_r[s+1] <= n_n;
        rq_r[s+1] <= q_n;
        rw_r[s+1] <= rw_r[s];
        ra_r[s+1] <= ra_r[s];
      end
    end
  end

  logic [31:0] len;
  assign len = rq_r[RS];

  // Quotient fits in 33 bits since |c| <= L; numerators are 63 bits.
  logic [32:0] dq_r [DS+1][3];
  logic [32:0] dr_r [DS+1][3];
  logic [62:0] dn_r [DS+1][3];
  logic [31:0] dl_r [DS+1];
  logic        ds_r [DS+1][3];
  vft_aux_t    da_r [DS+1];

  always_comb begin
    dl_r[0] = len;
    da_r[0] = ra_r[RS];
    for (int i = 0; i < 3; i++) begin
      logic [31:0] a;
      a = rw_r[RS][i][31] ? 32'(-rw_r[RS][i]) : 32'(rw_r[RS][i]);
      dn_r[0][i] = ({31'd0, a} << 30) + 63'(len >> 1);
      dq_r[0][i] = '0;
      dr_r[0][i] = '0;
      ds_r[0][i] = rw_r[RS][i][31];
    end
  end

  for (genvar s = 0; s < DS; s++) begin : g_div
    logic [32:0] q_n [3];
    logic [32:0] r_n [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        logic [33:0] t;
        q_n[i] = dq_r[s][i];
        r_n[i] = dr_r[s][i];
        for (int k = 0; k < DB; k++) begin
          int b;
          b = 62 - s*DB - k;
          t = {r_n[i], dn_r[s][i][b]};
          if (t >= {2'd0, dl_r[s]}) begin
            t = t - {2'd0, dl_r[s]};
            q_n[i] = {q_n[i][31:0], 1'b1};
          end else begin
            q_n[i] = {q_n[i][31:0], 1'b0};
          end
          r_n[i] = t[32:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dq_r[s+1] <= q_n;
        dr_r[s+1] <= r_n;
        dn_r[s+1] <= dn_r[s];
        dl_r[s+1] <= dl_r[s];
        ds_r[s+1] <= ds_r[s];
        da_r[s+1] <= da_r[s];
      end
    end
  end

  logic signed [31:0] res [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [63:0] q;
      q = 64'(dq_r[DS][i]);
      res[i] = sat32(ds_r[DS][i] ? -q : q);
    end
  end

  assign n_x = res[0];
  assign n_y = res[1];
  assign n_z = res[2];
  assign aux_o = da_r[DS];

endmodule

// ===== test/vertex_frame_transform_top_tb.sv =====
`timescale 1ns / 1ps
module vertex_frame_transform_top_tb;
  import vft_pkg::*;

  class frame_scoreboard;
    logic [62:0] rows[3];
    longint      ofs[3];
    logic [63:0] quat;
    vft_out_t    pending[$];
    int          errors;
    int          checked;

    function void reset_regs();
      for (int i = 0; i < 3; i++) begin
        rows[i] = '0;
        ofs[i] = 0;
      end
      quat = 64'h0000_0000_4000_0000;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] val);
      case (idx)
        REG_ROW_X, REG_ROW_Y, REG_ROW_Z: begin
          rows[int'(idx)] = val[62:0];
        end
        REG_OFS_X, REG_OFS_Y, REG_OFS_Z: begin
          ofs[int'(idx) - int'(REG_OFS_X)] = longint'($signed(val[39:0]));
        end
        REG_QUAT: begin
          quat = val;
        end
        default: begin
        end
      endcase
    endfunction

    function longint clamp(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void mul_linear(longint v[3], output longint o[3]);
      longint acc;
      longint k;
      for (int r = 0; r < 3; r++) begin
        acc = 0;
        for (int c = 0; c < 3; c++) begin
          k = longint'($signed(rows[r][62 - 21 * c -: 21]));
          acc += k * v[c];
        end
        o[r] = (acc + (longint'(1) <<< 17)) >>> 18;
      end
    endfunction

    function void rotate(longint v[3], output longint o[3]);
      longint qx, qy, qz, qw, one, sh, sl;
      longint m[9];
      longint vh[3];
      longint vl[3];
      qx = longint'($signed(quat[63:48]));
      qy = longint'($signed(quat[47:32]));
      qz = longint'($signed(quat[31:16]));
      qw = longint'($signed(quat[15:0]));
      one = longint'(1) <<< 28;
      m[0] = one - 2 * (qy * qy + qz * qz);
      m[1] = 2 * (qx * qy - qw * qz);
      m[2] = 2 * (qx * qz + qw * qy);
      m[3] = 2 * (qx * qy + qw * qz);
      m[4] = one - 2 * (qx * qx + qz * qz);
      m[5] = 2 * (qy * qz - qw * qx);
      m[6] = 2 * (qx * qz - qw * qy);
      m[7] = 2 * (qy * qz + qw * qx);
      m[8] = one - 2 * (qx * qx + qy * qy);
      for (int c = 0; c < 3; c++) begin
        vh[c] = v[c] >>> 20;
        vl[c] = v[c] - (vh[c] <<< 20);
      end
      for (int r = 0; r < 3; r++) begin
        sh = 0;
        sl = longint'(1) <<< 27;
        for (int c = 0; c < 3; c++) begin
          sh += m[r * 3 + c] * vh[c];
          sl += m[r * 3 + c] * vl[c];
        end
        o[r] = (sh + (sl >>> 20)) >>> 8;
      end
    endfunction

    function void to_unit(longint v[3], output longint o[3]);
      longint w[3];
      longint unsigned mag[3];
      longint unsigned mx, a, sumsq, len, q;
      int s;
      if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
        o[0] = 0;
        o[1] = longint'(1) <<< 30;
        o[2] = 0;
        return;
      end
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        a = v[i] < 0 ? longint'(-v[i]) : v[i];
        if (a > mx) mx = a;
        w[i] = v[i];
      end
      if (mx >= (64'd1 << 31)) begin
        s = 0;
        while ((mx >> s) >= (64'd1 << 31)) s++;
        for (int i = 0; i < 3; i++) w[i] = w[i] >>> s;
      end else begin
        while (mx < (64'd1 << 30)) begin
          mx = mx << 1;
          for (int i = 0; i < 3; i++) w[i] = w[i] * 2;
        end
      end
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = w[i] < 0 ? longint'(-w[i]) : w[i];
        sumsq += mag[i] * mag[i];
      end
      len = floor_sqrt(sumsq);
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << 30) + len / 2) / len;
        o[i] = clamp(w[i] < 0 ? -longint'(q) : longint'(q), 32);
      end
    endfunction

    function void note_input(vft_in_t d);
      longint v[3];
      longint a[3];
      longint b[3];
      longint r[3];
      vft_out_t e;
      v[0] = d.in_x;
      v[1] = d.in_y;
      v[2] = d.in_z;
      mul_linear(v, a);
      if (d.opcode == OP_POSITION) begin
        for (int i = 0; i < 3; i++) a[i] += ofs[i];
        rotate(a, b);
        for (int i = 0; i < 3; i++) r[i] = clamp(b[i], 32);
      end else begin
        rotate(a, b);
        to_unit(b, r);
      end
      e.kind = d.opcode;
      e.out_x = r[0][31:0];
      e.out_y = r[1][31:0];
      e.out_z = r[2][31:0];
      pending.push_back(e);
    endfunction

    function void check_result(vft_out_t got);
      vft_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat: kind %0d x %0d y %0d z %0d",
               got.kind, got.out_x, got.out_y, got.out_z);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.kind !== e.kind) begin
        $error("kind expected %0d actual %0d", e.kind, got.kind);
        errors++;
      end
      if (got.out_x !== e.out_x) begin
        $error("out_x expected %0d actual %0d", e.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== e.out_y) begin
        $error("out_y expected %0d actual %0d", e.out_y, got.out_y);
        errors++;
      end
      if (got.out_z !== e.out_z) begin
        $error("out_z expected %0d actual %0d", e.out_z, got.out_z);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  vft_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  vft_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_scoreboard sb;
  int stall_mode = 0;
  int gaps_on = 0;
  int burst_left = 0;
  int ready_cyc = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int cfg_writes = 0;

  vertex_frame_transform_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    ready_cyc++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((ready_cyc % 7) < 4);
      default: out_ready <= ((ready_cyc % 40) >= 25);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(reg_idx_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
          (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_cfg(reg_idx_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_writes++;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_frame(logic [62:0] rx, logic [62:0] ry, logic [62:0] rz,
                            logic [39:0] ox, logic [39:0] oy, logic [39:0] oz,
                            logic [63:0] q);
    write_cfg(REG_ROW_X, {1'b0, rx});
    write_cfg(REG_ROW_Y, {1'b0, ry});
    write_cfg(REG_ROW_Z, {1'b0, rz});
    write_cfg(REG_OFS_X, {24'd0, ox});
    write_cfg(REG_OFS_Y, {24'd0, oy});
    write_cfg(REG_OFS_Z, {24'd0, oz});
    write_cfg(REG_QUAT, q);
    if ($urandom_range(0, 1)) write_cfg(REG_UNUSED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_vertex(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vft_in_t d;
    d.opcode = op;
    d.in_x = x;
    d.in_y = y;
    d.in_z = z;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on != 0) begin
        repeat ($urandom_range(1, 6)) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= d;
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 2000) - 1000;
      3: return 32'h4000_0000 ^ ($urandom & 32'h0000_ffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [20:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 21'h0f_ffff;
      1: return 21'h10_0000;
      2: return 21'(21'h04_0000 + $urandom_range(0, 4096) - 2048);
      3: return 21'h0;
      default: return 21'($urandom);
    endcase
  endfunction

  function automatic logic [62:0] pick_row();
    return {pick_coef(), pick_coef(), pick_coef()};
  endfunction

  function automatic logic [39:0] pick_offset();
    case ($urandom_range(0, 4))
      0: return 40'h7f_ffff_ffff;
      1: return 40'h80_0000_0000;
      2: return 40'(signed'($urandom_range(0, 200000)) - 100000);
      default: return 40'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [63:0] pick_quat();
    case ($urandom_range(0, 4))
      0: return 64'h0000_0000_0000_4000;
      1: return 64'h2d41_0000_0000_2d41;
      2: return 64'hffff_ffff_ffff_ffff;
      3: return 64'h7fff_8000_7fff_8000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  localparam logic [62:0] ROW_X_ID = {21'h04_0000, 21'h0, 21'h0};
  localparam logic [62:0] ROW_Y_ID = {21'h0, 21'h04_0000, 21'h0};
  localparam logic [62:0] ROW_Z_ID = {21'h0, 21'h0, 21'h04_0000};

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_vertex(OP_NORMAL, 32'h4000_0000, 32'h0, 32'h0);
    send_vertex(OP_POSITION, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
    send_vertex(OP_NORMAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();

    load_frame(ROW_X_ID, ROW_Y_ID, ROW_Z_ID, 40'h7f_ffff_ffff, 40'h80_0000_0000,
               40'h0, 64'h0000_0000_0000_4000);
    send_vertex(OP_POSITION, 32'h0, 32'h0, 32'h0);
    send_vertex(OP_POSITION, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(OP_POSITION, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(OP_NORMAL, 32'h0, 32'h0, 32'h0);
    send_vertex(OP_NORMAL, 32'h1, 32'h0, 32'h0);
    send_vertex(OP_NORMAL, 32'h0, 32'hffff_ffff, 32'h0);
    send_vertex(OP_NORMAL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(OP_NORMAL, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
    send_vertex(OP_NORMAL, 32'h4000_0000, 32'h4000_0000, 32'h0);
    drain();

    load_frame({3{21'h0f_ffff}}, {3{21'h10_0000}}, ROW_Z_ID, 40'h0,
               40'h7f_ffff_ffff, 40'h80_0000_0000, 64'hffff_ffff_ffff_ffff);
    send_vertex(OP_POSITION, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_vertex(OP_NORMAL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_vertex(OP_POSITION, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    send_vertex(OP_NORMAL, 32'h0, 32'h0, 32'h1);
    drain();

    for (int p = 0; p < 7; p++) begin
      stall_mode = p % 4;
      gaps_on = (p % 3 != 0);
      if (p == 0) begin
        load_frame(ROW_X_ID, ROW_Y_ID, ROW_Z_ID, pick_offset(), pick_offset(),
                   pick_offset(), 64'h2d41_0000_0000_2d41);
      end else begin
        load_frame(pick_row(), pick_row(), pick_row(), pick_offset(), pick_offset(),
                   pick_offset(), pick_quat());
      end
      repeat (200) begin
        send_vertex(1'($urandom_range(0, 1)), pick_coord(), pick_coord(), pick_coord());
      end
      drain();
    end

    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Ran %0d vertices through %0d register writes with varied stalls,",
             items_sent, cfg_writes);
    $display("and compared %0d result beats field by field.", sb.checked);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== vertex_frame_transform_top.f =====
rtl/core/vft_pkg.sv
rtl/core/vft_cfg.sv
rtl/core/vft_pipe.sv
rtl/core/vft_norm.sv
rtl/core/vertex_frame_transform_top.sv
test/vertex_frame_transform_top_tb.sv
